// ----- rtl/eyvm_pkg.sv -----
`default_nettype none
package eyvm_pkg;
	localparam int CordicSteps = 16;
	localparam logic signed [26:0] AngToPhase = 27'sd42722830;
	localparam logic signed [33:0] CordicX0 = 34'sd652032874;

	// Arctangent of 2^-i in phase units, one full turn is 2^24.
	function automatic logic signed [24:0] atan_phase(input int idx);
		logic signed [24:0] r;
		begin
			case (idx)
				0: r = 25'sd2097152;
				1: r = 25'sd1238021;
				2: r = 25'sd654136;
				3: r = 25'sd332050;
				4: r = 25'sd166669;
				5: r = 25'sd83416;
				6: r = 25'sd41718;
				7: r = 25'sd20860;
				8: r = 25'sd10430;
				9: r = 25'sd5215;
				10: r = 25'sd2608;
				11: r = 25'sd1304;
				12: r = 25'sd652;
				13: r = 25'sd326;
				14: r = 25'sd163;
				default: r = 25'sd81;
			endcase
			return r;
		end
	endfunction

	// One CORDIC cell's data: three angles carried in parallel.
	typedef struct packed {
		logic signed [2:0][33:0] x;
		logic signed [2:0][33:0] y;
		logic signed [2:0][24:0] z;
		logic [2:0][1:0] quad;
	} cordic_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pos_t;
endpackage
`default_nettype wire

// ----- rtl/eyvm_if.sv -----
`default_nettype none
interface eyvm_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] angle_x;
	logic signed [15:0] angle_y;
	logic signed [15:0] angle_z;
	modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
		output ready);
endinterface

interface eyvm_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] u_x;
	logic signed [15:0] u_y;
	logic signed [15:0] u_z;
	logic signed [15:0] v_x;
	logic signed [15:0] v_y;
	logic signed [15:0] v_z;
	logic signed [15:0] w_x;
	logic signed [15:0] w_y;
	logic signed [15:0] w_z;
	logic signed [31:0] shift_u;
	logic signed [31:0] shift_v;
	logic signed [31:0] shift_w;
	modport source (output valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z,
		shift_u, shift_v, shift_w, input ready);
	modport sink (input valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z,
		shift_u, shift_v, shift_w, output ready);
endinterface
`default_nettype wire

// ----- rtl/euler_yxz_view_matrix.sv -----
`default_nettype none
// A pipeline of fixed stages: the input stage, the CORDIC cell row and the post stages.
// Throughput: one item per cycle while the output is not stalled; the depth of the
// CORDIC cell row and the multiplier stages after it set the latency.
// The pipeline advances whenever its last stage is empty or being taken.
// Reset clears all valid flags; payload registers are not reset.
module euler_yxz_view_matrix
	import eyvm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	eyvm_in_if.sink in_ch,
	eyvm_out_if.source out_ch
);
	localparam int NPost = 9;

	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: angle times phase scale.
	logic v_s1;
	logic signed [42:0] prod_s1 [3];
	pos_t pos_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= 43'(in_ch.angle_x * AngToPhase);
			prod_s1[1] <= 43'(in_ch.angle_y * AngToPhase);
			prod_s1[2] <= 43'(in_ch.angle_z * AngToPhase);
			pos_s1 <= '{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
		end
	end

	// Phase rounding and quadrant split feed the first cell.
	cordic_t c0;
	always_comb begin
		logic [42:0] ph;
		for (int a = 0; a < 3; a++) begin
			ph = prod_s1[a] + 43'sd32768;
			c0.quad[a] = ph[39:38];
			c0.z[a] = 25'({3'b000, ph[37:16]});
			c0.x[a] = CordicX0;
			c0.y[a] = '0;
		end
	end

	logic vc [CordicSteps+1];
	cordic_t cd [CordicSteps+1];
	pos_t pc [CordicSteps+1];
	assign vc[0] = v_s1;
	assign cd[0] = c0;
	assign pc[0] = pos_s1;
	for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
		eyvm_cell #(.Step(g)) u_cell (
			.clk, .arst_n, .en,
			.vin(vc[g]), .din(cd[g]), .pin(pc[g]),
			.vout(vc[g+1]), .dout(cd[g+1]), .pout(pc[g+1])
		);
	end

	// Post stages: sin/cos, products, rounding, dot products.
	logic v_p [NPost];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPost; i++) v_p[i] <= 1'b0;
		end else if (en) begin
			v_p[0] <= vc[CordicSteps];
			for (int i = 1; i < NPost; i++) v_p[i] <= v_p[i-1];
		end
	end
	assign out_ch.valid = v_p[NPost-1];

	// P0: rounded sine/cosine, Q16 (index 0 = angle_x, 1 = angle_y, 2 = angle_z).
	logic signed [17:0] sn_a, cs_a [3];
	logic signed [17:0] sn [3];
	logic signed [17:0] cs [3];
	pos_t pos_a;
	always_ff @(posedge clk) begin
		logic signed [19:0] xr, yr;
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				xr = 20'(($signed(cd[CordicSteps].x[a]) + 34'sd8192) >>> 14);
				yr = 20'(($signed(cd[CordicSteps].y[a]) + 34'sd8192) >>> 14);
				case (cd[CordicSteps].quad[a])
					2'd0: begin sn[a] <= 18'(yr); cs[a] <= 18'(xr); end
					2'd1: begin sn[a] <= 18'(xr); cs[a] <= 18'(-yr); end
					2'd2: begin sn[a] <= 18'(-yr); cs[a] <= 18'(-xr); end
					default: begin sn[a] <= 18'(-xr); cs[a] <= 18'(yr); end
				endcase
			end
			pos_a <= pc[CordicSteps];
		end
	end
	assign sn_a = sn[0];
	assign cs_a = cs;

	// s1,c1 = y angle; s2,c2 = x angle; s3,c3 = z angle.
	logic signed [17:0] s1, c1, s2, c2, s3, c3;
	assign s1 = sn[1]; assign c1 = cs[1];
	assign s2 = sn_a;  assign c2 = cs_a[0];
	assign s3 = sn[2]; assign c3 = cs[2];

	// P1: pairwise products (Q32).
	logic signed [35:0] c1c3, s1s2, c2s3, c1s2, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2;
	logic signed [17:0] s3_1, c3_1, s2_1;
	pos_t pos_b;
	always_ff @(posedge clk) begin
		if (en) begin
			c1c3 <= c1 * c3; s1s2 <= s1 * s2; c2s3 <= c2 * s3; c1s2 <= c1 * s2;
			c3s1 <= c3 * s1; c1s3 <= c1 * s3; c2c3 <= c2 * c3; s1s3 <= s1 * s3;
			c2s1 <= c2 * s1; c1c2 <= c1 * c2;
			s3_1 <= s3; c3_1 <= c3; s2_1 <= s2; pos_b <= pos_a;
		end
	end

	// P2: triple products (Q48) and scaled pair terms.
	logic signed [53:0] t_a, t_c, t_d, t_f;
	logic signed [53:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	pos_t pos_c;
	always_ff @(posedge clk) begin
		if (en) begin
			t_a <= s1s2 * s3_1;
			t_c <= c1s2 * s3_1;
			t_d <= s1s2 * c3_1;
			t_f <= c1s2 * c3_1;
			p1 <= 54'(c1c3) <<< 16;
			p2 <= 54'(c2s3) <<< 16;
			p3 <= 54'(c3s1) <<< 16;
			p4 <= 54'(c1s3) <<< 16;
			p5 <= 54'(c2c3) <<< 16;
			p6 <= 54'(s1s3) <<< 16;
			p7 <= 54'(c2s1) <<< 16;
			p8 <= -(54'(s2_1) <<< 32);
			p9 <= 54'(c1c2) <<< 16;
			pos_c <= pos_b;
		end
	end

	// P3: Q48 entries.
	logic signed [55:0] q48 [9];
	pos_t pos_d;
	always_ff @(posedge clk) begin
		if (en) begin
			q48[0] <= 56'(p1) + 56'(t_a);
			q48[1] <= 56'(p2);
			q48[2] <= 56'(t_c) - 56'(p3);
			q48[3] <= 56'(t_d) - 56'(p4);
			q48[4] <= 56'(p5);
			q48[5] <= 56'(t_f) + 56'(p6);
			q48[6] <= 56'(p7);
			q48[7] <= 56'(p8);
			q48[8] <= 56'(p9);
			pos_d <= pos_c;
		end
	end

	// P4: round to Q14 and saturate.
	logic signed [15:0] e [9];
	pos_t pos_e;
	always_ff @(posedge clk) begin
		logic signed [55:0] r;
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				r = (q48[i] + (56'sd1 <<< 33)) >>> 34;
				if (r > 56'sd16384) e[i] <= 16'sd16384;
				else if (r < -56'sd16384) e[i] <= -16'sd16384;
				else e[i] <= 16'(r);
			end
			pos_e <= pos_d;
		end
	end

	// P5: entry times position products.
	logic signed [47:0] m [9];
	logic signed [15:0] e5 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				m[3*r]   <= e[3*r]   * pos_e.pos_x;
				m[3*r+1] <= e[3*r+1] * pos_e.pos_y;
				m[3*r+2] <= e[3*r+2] * pos_e.pos_z;
			end
			e5 <= e;
		end
	end

	// P6: dot product sums.
	logic signed [49:0] dsum [3];
	logic signed [15:0] e6 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				dsum[r] <= -(50'(m[3*r]) + 50'(m[3*r+1]) + 50'(m[3*r+2]));
			e6 <= e5;
		end
	end

	// P7: round to Q16.
	logic signed [49:0] rs [3];
	logic signed [15:0] e7 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) rs[r] <= (dsum[r] + 50'sd8192) >>> 14;
			e7 <= e6;
		end
	end

	// P8: saturate into the output register.
	logic signed [31:0] sh [3];
	logic signed [15:0] e8 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				if (rs[r] > 50'sd2147483647) sh[r] <= 32'sh7fffffff;
				else if (rs[r] < -50'sd2147483648) sh[r] <= 32'sh80000000;
				else sh[r] <= 32'(rs[r]);
			end
			e8 <= e7;
		end
	end

	assign out_ch.u_x = e8[0];
	assign out_ch.u_y = e8[1];
	assign out_ch.u_z = e8[2];
	assign out_ch.v_x = e8[3];
	assign out_ch.v_y = e8[4];
	assign out_ch.v_z = e8[5];
	assign out_ch.w_x = e8[6];
	assign out_ch.w_y = e8[7];
	assign out_ch.w_z = e8[8];
	assign out_ch.shift_u = sh[0];
	assign out_ch.shift_v = sh[1];
	assign out_ch.shift_w = sh[2];
endmodule
`default_nettype wire

// ----- rtl/eyvm_cell.sv -----
`default_nettype none
module eyvm_cell
	import eyvm_pkg::*;
#(
	parameter int Step = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vin,
	input wire cordic_t din,
	input wire pos_t pin,
	output logic vout,
	output cordic_t dout,
	output pos_t pout
);
	cordic_t nxt;

	// One rotation step for each of the three angles.
	// Elements of a packed array read as unsigned, so each one is made signed here.
	always_comb begin
		nxt = din;
		for (int a = 0; a < 3; a++) begin
			if ($signed(din.z[a]) >= 0) begin
				nxt.x[a] = $signed(din.x[a]) - ($signed(din.y[a]) >>> Step);
				nxt.y[a] = $signed(din.y[a]) + ($signed(din.x[a]) >>> Step);
				nxt.z[a] = $signed(din.z[a]) - atan_phase(Step);
			end else begin
				nxt.x[a] = $signed(din.x[a]) + ($signed(din.y[a]) >>> Step);
				nxt.y[a] = $signed(din.y[a]) - ($signed(din.x[a]) >>> Step);
				nxt.z[a] = $signed(din.z[a]) + atan_phase(Step);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
			pout <= pin;
		end
	end
endmodule
`default_nettype wire
